// ===== rtl/core/softened_gravity_pair_kick_assert.svh =====
// ----------------------------------------------------------------------------
// softened gravity pair kick assertion macros
// shared concurrent checks clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef SOFTENED_GRAVITY_PAIR_KICK_ASSERT_SVH
`define SOFTENED_GRAVITY_PAIR_KICK_ASSERT_SVH

// condition holds on every edge
`define SGPK_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("sgpk check failed");

// same-cycle implication
`define SGPK_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sgpk implication failed");

`endif

// ===== rtl/core/sgpk_pkg.sv =====
// ----------------------------------------------------------------------------
// sgpk_pkg
// widths, constants and the side payload of the pair kick pipeline
// ----------------------------------------------------------------------------
package sgpk_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  localparam int MASS_W    = WORD_BITS - 1;
  localparam int SOFT_W    = WORD_BITS - 1;
  localparam int DX_W      = WORD_BITS + 1;
  localparam int SQ_W      = 2 * DX_W;
  localparam int SOFT_SH_W = SOFT_W + FRAC_BITS;
  localparam int R2_W      = ((SOFT_SH_W > SQ_W) ? SOFT_SH_W : SQ_W) + 2;
  localparam int ROOT_W    = (R2_W + 1) / 2;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int P_W       = 2 * WORD_BITS;
  localparam int NUM_W     = MASS_W + 3 * FRAC_BITS;
  localparam int Q_W       = NUM_W;
  localparam int RH_W      = (R2_W + 1) / 2;
  localparam int RPP_W     = RH_W + ROOT_W;
  localparam int D_W       = R2_W + ROOT_W;
  localparam int DR_W      = D_W + 1;
  localparam int A_W       = WORD_BITS + 2 * FRAC_BITS + 2;
  localparam int CH_W      = (A_W + 2) / 3;
  localparam int PP_W      = WORD_BITS + CH_W;
  localparam int ROW_W     = WORD_BITS + 3 * CH_W;
  localparam int PROD_W    = 2 * WORD_BITS + 3 * CH_W;
  localparam int SH        = 2 * FRAC_BITS;
  localparam int M_W       = WORD_BITS + 1;

  localparam logic [A_W-1:0] A_CAP = {1'b1, {(A_W-1){1'b0}}};
  localparam logic [M_W-1:0] M_CAP = {1'b1, {(M_W-1){1'b0}}};

  typedef struct packed {
    logic [2:0][WORD_BITS-1:0] vel;
    logic [2:0][P_W-1:0]       p;
    logic [2:0]                neg;
    logic [MASS_W-1:0]         mass;
    logic [R2_W-1:0]           r2;
    logic                      zero;
  } side_t;

endpackage

// ===== rtl/core/sgpk_if.sv =====
// ----------------------------------------------------------------------------
// sgpk channel interfaces
// valid/ready channels for interactions in and kicked velocities out
// ----------------------------------------------------------------------------
interface sgpk_in_if;
  import sgpk_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] pos_i_x;
  logic signed [WORD_BITS-1:0] pos_i_y;
  logic signed [WORD_BITS-1:0] pos_i_z;
  logic signed [WORD_BITS-1:0] pos_j_x;
  logic signed [WORD_BITS-1:0] pos_j_y;
  logic signed [WORD_BITS-1:0] pos_j_z;
  logic [MASS_W-1:0]           mass_j;
  logic signed [WORD_BITS-1:0] vel_in_x;
  logic signed [WORD_BITS-1:0] vel_in_y;
  logic signed [WORD_BITS-1:0] vel_in_z;
  logic signed [WORD_BITS-1:0] kick_step;

  modport source (output valid, pos_i_x, pos_i_y, pos_i_z, pos_j_x, pos_j_y, pos_j_z,
                  mass_j, vel_in_x, vel_in_y, vel_in_z, kick_step, input ready);
  modport sink (input valid, pos_i_x, pos_i_y, pos_i_z, pos_j_x, pos_j_y, pos_j_z,
                mass_j, vel_in_x, vel_in_y, vel_in_z, kick_step, output ready);
endinterface

interface sgpk_out_if;
  import sgpk_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] vel_out_x;
  logic signed [WORD_BITS-1:0] vel_out_y;
  logic signed [WORD_BITS-1:0] vel_out_z;
  logic                        saturated;

  modport source (output valid, vel_out_x, vel_out_y, vel_out_z, saturated, input ready);
  modport sink (input valid, vel_out_x, vel_out_y, vel_out_z, saturated, output ready);
endinterface

// ===== rtl/core/sgpk_isqrt.sv =====
// ----------------------------------------------------------------------------
// sgpk_isqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module sgpk_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [sgpk_pkg::R2_W-1:0]   rad,
  input  sgpk_pkg::side_t             in_side,
  output logic                        out_vld,
  output logic [sgpk_pkg::ROOT_W-1:0] root,
  output sgpk_pkg::side_t             out_side
);
  import sgpk_pkg::*;

  localparam int REM_W = ROOT_W + 3;

  logic              vld_r  [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [RAD_W-1:0]  rad_r  [ROOT_W];
  side_t             side_r [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    logic              vld_prev;
    logic [REM_W-1:0]  rem_prev;
    logic [ROOT_W-1:0] root_prev;
    logic [RAD_W-1:0]  rad_prev;
    side_t             side_prev;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;

    if (s == 0) begin : g_first
      assign vld_prev  = in_vld;
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign rad_prev  = RAD_W'(rad);
      assign side_prev = in_side;
    end else begin : g_next
      assign vld_prev  = vld_r[s-1];
      assign rem_prev  = rem_r[s-1];
      assign root_prev = root_r[s-1];
      assign rad_prev  = rad_r[s-1];
      assign side_prev = side_r[s-1];
    end

    assign rem_sh = {rem_prev[REM_W-3:0], rad_prev[RAD_W-1 -: 2]};
    assign trial  = REM_W'({root_prev, 2'b01});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_sh >= trial) begin
          rem_r[s]  <= rem_sh - trial;
          root_r[s] <= {root_prev[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r[s]  <= rem_sh;
          root_r[s] <= {root_prev[ROOT_W-2:0], 1'b0};
        end
        rad_r[s]  <= rad_prev << 2;
        side_r[s] <= side_prev;
      end
    end
  end

  assign out_vld  = vld_r[ROOT_W-1];
  assign root     = root_r[ROOT_W-1];
  assign out_side = side_r[ROOT_W-1];

endmodule

// ===== rtl/core/sgpk_div.sv =====
// ----------------------------------------------------------------------------
// sgpk_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module sgpk_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [sgpk_pkg::NUM_W-1:0] num,
  input  logic [sgpk_pkg::D_W-1:0]   den,
  input  sgpk_pkg::side_t            in_side,
  output logic                       out_vld,
  output logic [sgpk_pkg::Q_W-1:0]   quo,
  output sgpk_pkg::side_t            out_side
);
  import sgpk_pkg::*;

  logic             vld_r  [Q_W];
  logic [DR_W-1:0]  rem_r  [Q_W];
  logic [Q_W-1:0]   quo_r  [Q_W];
  logic [NUM_W-1:0] num_r  [Q_W];
  logic [D_W-1:0]   den_r  [Q_W];
  side_t            side_r [Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    logic             vld_prev;
    logic [DR_W-1:0]  rem_prev;
    logic [Q_W-1:0]   quo_prev;
    logic [NUM_W-1:0] num_prev;
    logic [D_W-1:0]   den_prev;
    side_t            side_prev;
    logic [DR_W-1:0]  rem_sh;
    logic             ge;

    if (s == 0) begin : g_first
      assign vld_prev  = in_vld;
      assign rem_prev  = '0;
      assign quo_prev  = '0;
      assign num_prev  = num;
      assign den_prev  = den;
      assign side_prev = in_side;
    end else begin : g_next
      assign vld_prev  = vld_r[s-1];
      assign rem_prev  = rem_r[s-1];
      assign quo_prev  = quo_r[s-1];
      assign num_prev  = num_r[s-1];
      assign den_prev  = den_r[s-1];
      assign side_prev = side_r[s-1];
    end

    assign rem_sh = {rem_prev[DR_W-2:0], num_prev[NUM_W-1]};
    assign ge     = rem_sh >= DR_W'(den_prev);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= ge ? (rem_sh - DR_W'(den_prev)) : rem_sh;
        quo_r[s]  <= {quo_prev[Q_W-2:0], ge};
        num_r[s]  <= num_prev << 1;
        den_r[s]  <= den_prev;
        side_r[s] <= side_prev;
      end
    end
  end

  assign out_vld  = vld_r[Q_W-1];
  assign quo      = quo_r[Q_W-1];
  assign out_side = side_r[Q_W-1];

endmodule

// ===== rtl/core/softened_gravity_pair_kick.sv =====
// ----------------------------------------------------------------------------
// softened_gravity_pair_kick
// softened pairwise gravity velocity kick, signed fixed point, saturating
//
//   channel   dir  handshake          contents
//   in_chan   in   valid/ready        positions i and j, mass j, velocity, step
//   out_chan  out  valid/ready        kicked velocity, saturated flag
//   cfg_*     in   write enable only  softening_squared
//
// one interaction per cycle sustained while out_chan accepts results; the
// pipeline holds the 34 square-root stages (ROOT_W) and the 79 stages (Q_W) of the
// divider for mass / (r2 * sqrt(r2))
// reset is synchronous and clears the valid bits and softening_squared
// a waiting result holds the whole pipeline; nothing is dropped or repeated
// ----------------------------------------------------------------------------
`include "softened_gravity_pair_kick_assert.svh"

module softened_gravity_pair_kick (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [sgpk_pkg::SOFT_W-1:0] cfg_wdata,
  sgpk_in_if.sink                    in_chan,
  sgpk_out_if.source                 out_chan
);
  import sgpk_pkg::*;

  logic en;
  logic [SOFT_W-1:0] soft_r;

  // stage 1: separation
  logic                          s1_vld_r;
  logic [2:0][DX_W-1:0]          s1_dm_r, s1_dm_nxt;
  logic [2:0]                    s1_neg_r, s1_neg_nxt;
  logic [WORD_BITS-1:0]          s1_tmag_r, s1_tmag_nxt;
  logic [2:0][WORD_BITS-1:0]     s1_vel_r;
  logic [MASS_W-1:0]             s1_mass_r;
  logic [2:0][WORD_BITS-1:0]     pi, pj;
  logic [2:0][DX_W-1:0]          dx;

  // stage 2: squares and step products
  logic                          s2_vld_r;
  logic [2:0][SQ_W-1:0]          s2_sq_r, s2_sq_nxt;
  logic [2:0][P_W-1:0]           s2_p_r, s2_p_nxt;
  logic [2:0]                    s2_neg_r;
  logic [2:0][WORD_BITS-1:0]     s2_vel_r;
  logic [MASS_W-1:0]             s2_mass_r;
  logic [2*WORD_BITS:0]          pfull [3];

  // stage 3: r2
  logic                          s3_vld_r;
  side_t                         s3_side_r, s3_side_nxt;

  logic                          sq_vld;
  logic [ROOT_W-1:0]             sq_root;
  side_t                         sq_side;

  // stages 4, 5: r2 * root
  logic                          s4_vld_r;
  logic [RPP_W-1:0]              s4_pp_lo_r, s4_pp_hi_r;
  side_t                         s4_side_r;
  logic                          s5_vld_r;
  logic [D_W-1:0]                s5_d_r;
  side_t                         s5_side_r;

  logic                          dv_vld;
  logic [Q_W-1:0]                dv_quo;
  side_t                         dv_side;

  // stages 6..9: dv magnitude
  logic [A_W-1:0]                a6;
  logic [3*CH_W-1:0]             a_pad;
  logic                          s6_vld_r;
  logic [2:0][1:0][2:0][PP_W-1:0] s6_pp_r, s6_pp_nxt;
  side_t                         s6_side_r;
  logic                          s7_vld_r;
  logic [2:0][1:0][ROW_W-1:0]    s7_row_r, s7_row_nxt;
  side_t                         s7_side_r;
  logic                          s8_vld_r;
  logic [2:0][PROD_W-1:0]        s8_prod_r, s8_prod_nxt;
  side_t                         s8_side_r;
  logic                          s9_vld_r;
  logic [2:0][M_W-1:0]           s9_m_r, s9_m_nxt;
  side_t                         s9_side_r;

  // output register
  logic                          out_vld_r;
  logic [2:0][WORD_BITS-1:0]     out_vel_r, out_vel_nxt;
  logic                          out_sat_r, out_sat_nxt;
  logic                          out_zero_r;
  logic signed [WORD_BITS+1:0]   vsum [3];

  assign en            = !out_vld_r || out_chan.ready;
  assign in_chan.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      soft_r <= '0;
    end else if (cfg_we) begin
      soft_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      s6_vld_r  <= 1'b0;
      s7_vld_r  <= 1'b0;
      s8_vld_r  <= 1'b0;
      s9_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r  <= in_chan.valid;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= sq_vld;
      s5_vld_r  <= s4_vld_r;
      s6_vld_r  <= dv_vld;
      s7_vld_r  <= s6_vld_r;
      s8_vld_r  <= s7_vld_r;
      s9_vld_r  <= s8_vld_r;
      out_vld_r <= s9_vld_r;
    end
  end

  always_comb begin
    pi = {in_chan.pos_i_z, in_chan.pos_i_y, in_chan.pos_i_x};
    pj = {in_chan.pos_j_z, in_chan.pos_j_y, in_chan.pos_j_x};
    for (int k = 0; k < 3; k++) begin
      dx[k]         = {pi[k][WORD_BITS-1], pi[k]} - {pj[k][WORD_BITS-1], pj[k]};
      s1_dm_nxt[k]  = dx[k][DX_W-1] ? (~dx[k] + 1'b1) : dx[k];
      s1_neg_nxt[k] = in_chan.kick_step[WORD_BITS-1] ^ dx[k][DX_W-1];
    end
    s1_tmag_nxt = in_chan.kick_step[WORD_BITS-1] ? (~in_chan.kick_step + 1'b1)
                                                 : in_chan.kick_step;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dm_r   <= s1_dm_nxt;
      s1_neg_r  <= s1_neg_nxt;
      s1_tmag_r <= s1_tmag_nxt;
      s1_vel_r  <= {in_chan.vel_in_z, in_chan.vel_in_y, in_chan.vel_in_x};
      s1_mass_r <= in_chan.mass_j;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s2_sq_nxt[k] = s1_dm_r[k] * s1_dm_r[k];
      pfull[k]     = s1_tmag_r * s1_dm_r[k];
      s2_p_nxt[k]  = pfull[k][P_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sq_r   <= s2_sq_nxt;
      s2_p_r    <= s2_p_nxt;
      s2_neg_r  <= s1_neg_r;
      s2_vel_r  <= s1_vel_r;
      s2_mass_r <= s1_mass_r;
    end
  end

  always_comb begin
    s3_side_nxt.vel  = s2_vel_r;
    s3_side_nxt.p    = s2_p_r;
    s3_side_nxt.neg  = s2_neg_r;
    s3_side_nxt.mass = s2_mass_r;
    s3_side_nxt.r2   = R2_W'(s2_sq_r[0]) + R2_W'(s2_sq_r[1]) + R2_W'(s2_sq_r[2])
                     + R2_W'({soft_r, {FRAC_BITS{1'b0}}});
    s3_side_nxt.zero = (s3_side_nxt.r2 == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side_r <= s3_side_nxt;
    end
  end

  sgpk_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s3_vld_r),
    .rad      (s3_side_r.r2),
    .in_side  (s3_side_r),
    .out_vld  (sq_vld),
    .root     (sq_root),
    .out_side (sq_side)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      s4_pp_lo_r <= RPP_W'(sq_side.r2[RH_W-1:0]) * RPP_W'(sq_root);
      s4_pp_hi_r <= RPP_W'(sq_side.r2[R2_W-1:RH_W]) * RPP_W'(sq_root);
      s4_side_r  <= sq_side;
      s5_d_r     <= D_W'(s4_pp_lo_r) + (D_W'(s4_pp_hi_r) << RH_W);
      s5_side_r  <= s4_side_r;
    end
  end

  sgpk_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s5_vld_r),
    .num      ({s5_side_r.mass, {(3*FRAC_BITS){1'b0}}}),
    .den      (s5_d_r),
    .in_side  (s5_side_r),
    .out_vld  (dv_vld),
    .quo      (dv_quo),
    .out_side (dv_side)
  );

  always_comb begin
    a6    = (|dv_quo[Q_W-1:A_W-1]) ? A_CAP : dv_quo[A_W-1:0];
    a_pad = (3*CH_W)'(a6);
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 3; j++) begin
          s6_pp_nxt[k][i][j] = dv_side.p[k][i*WORD_BITS +: WORD_BITS]
                             * a_pad[j*CH_W +: CH_W];
        end
        s7_row_nxt[k][i] = ROW_W'(s6_pp_r[k][i][0])
                         + (ROW_W'(s6_pp_r[k][i][1]) << CH_W)
                         + (ROW_W'(s6_pp_r[k][i][2]) << (2*CH_W));
      end
      s8_prod_nxt[k] = PROD_W'(s7_row_r[k][0]) + (PROD_W'(s7_row_r[k][1]) << WORD_BITS);
      if ((|s8_prod_r[k][PROD_W-1:SH+WORD_BITS+1]) ||
          (s8_prod_r[k][SH+WORD_BITS] && (|s8_prod_r[k][SH+WORD_BITS-1:SH]))) begin
        s9_m_nxt[k] = M_CAP;
      end else begin
        s9_m_nxt[k] = s8_prod_r[k][SH+WORD_BITS:SH];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_pp_r   <= s6_pp_nxt;
      s6_side_r <= dv_side;
      s7_row_r  <= s7_row_nxt;
      s7_side_r <= s6_side_r;
      s8_prod_r <= s8_prod_nxt;
      s8_side_r <= s7_side_r;
      s9_m_r    <= s9_m_nxt;
      s9_side_r <= s8_side_r;
    end
  end

  always_comb begin
    out_sat_nxt = 1'b0;
    for (int k = 0; k < 3; k++) begin
      vsum[k] = s9_side_r.neg[k]
              ? ({{2{s9_side_r.vel[k][WORD_BITS-1]}}, s9_side_r.vel[k]} + {1'b0, s9_m_r[k]})
              : ({{2{s9_side_r.vel[k][WORD_BITS-1]}}, s9_side_r.vel[k]} - {1'b0, s9_m_r[k]});
      if (s9_side_r.zero) begin
        out_vel_nxt[k] = s9_side_r.vel[k];
      end else if ((vsum[k][WORD_BITS+1:WORD_BITS-1] != 3'b000) &&
                   (vsum[k][WORD_BITS+1:WORD_BITS-1] != 3'b111)) begin
        out_vel_nxt[k] = vsum[k][WORD_BITS+1] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                              : {1'b0, {(WORD_BITS-1){1'b1}}};
        out_sat_nxt    = 1'b1;
      end else begin
        out_vel_nxt[k] = vsum[k][WORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vel_r  <= out_vel_nxt;
      out_sat_r  <= out_sat_nxt;
      out_zero_r <= s9_side_r.zero;
    end
  end

  assign out_chan.valid     = out_vld_r;
  assign out_chan.vel_out_x = out_vel_r[0];
  assign out_chan.vel_out_y = out_vel_r[1];
  assign out_chan.vel_out_z = out_vel_r[2];
  assign out_chan.saturated = out_sat_r;

  // root is the floor square root of r2
  `SGPK_ASSERT_IMPL(a_root_floor, sq_vld,
    ((RAD_W+2)'(sq_root) * (RAD_W+2)'(sq_root) <= (RAD_W+2)'(sq_side.r2)) &&
    (((RAD_W+2)'(sq_root) + 1'b1) * ((RAD_W+2)'(sq_root) + 1'b1) > (RAD_W+2)'(sq_side.r2)))
  // x component of the dv magnitude never beyond M_CAP, 2**32
  `SGPK_ASSERT_ALWAYS(a_dv_cap, !s9_vld_r || !(s9_m_r[0][M_W-1] && (|s9_m_r[0][M_W-2:0])))
  // pass-through never clips
  `SGPK_ASSERT_IMPL(a_zero_no_clip, out_vld_r && out_zero_r, !out_sat_r)

endmodule
